// ===== rtl/odpq_pkg.sv =====
package odpq_pkg;

    // fixed field widths
    localparam int COORD_W = 12;
    localparam int CHAN_W  = 8;
    localparam int RGB_W   = 3 * CHAN_W;
    localparam int IDX_W   = 3;
    localparam int CNT_W   = 3;

    // palette storage and entries in use
    localparam int NUM_PAL    = 7;
    localparam int MAX_COLORS = 7;
    localparam int N_USE_MAX  = (MAX_COLORS < NUM_PAL) ? MAX_COLORS : NUM_PAL;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = RGB_W;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAL0  = 3'd1;

    localparam logic [CNT_W-1:0] COUNT_RESET = 3'd7;
    localparam logic [RGB_W-1:0] PAL_RESET [NUM_PAL] = '{
        24'h000000, 24'hFFFFFF, 24'h00FF00, 24'h0000FF,
        24'hFF0000, 24'hFFFF00, 24'hFF8000
    };

    // datapath widths
    localparam int OFF_W  = 8;   // dither offset, -46..40
    localparam int D_W    = 10;  // dithered channel and channel difference
    localparam int P_W    = 16;  // weighted difference, |59*301| < 2^15
    localparam int DIST_W = 29;  // sum of squares < 2^29

    // luma weights and dither amplitudes
    localparam int W_RED   = 30;
    localparam int W_GREEN = 59;
    localparam int W_BLUE  = 11;
    localparam int K_RED   = 92;
    localparam int K_GREEN = 85;
    localparam int K_BLUE  = 65;

    localparam logic [3:0] BAYER [4][4] = '{
        '{4'd0,  4'd8,  4'd2,  4'd10},
        '{4'd12, 4'd4,  4'd14, 4'd6},
        '{4'd3,  4'd11, 4'd1,  4'd9},
        '{4'd15, 4'd7,  4'd13, 4'd5}
    };

    // min tree shape
    localparam int L6_N = (NUM_PAL + 1) / 2;
    localparam int L7_N = (L6_N + 1) / 2;

    typedef struct packed {
        logic s3;
        logic s4;
        logic s5;
    } t_lane_en;

    typedef struct packed {
        logic                 vld;
        logic [IDX_W-1:0]     idx;
        logic [DIST_W-1:0]    dval;
    } t_cand;

    typedef struct packed {
        logic                 hit;
        logic [IDX_W-1:0]     hidx;
        logic [NUM_PAL-1:0]   mask;
    } t_side;

    // round half away from zero of k*(t-8)/16
    function automatic logic signed [OFF_W-1:0] f_offset(input int k, input logic [3:0] t);
        int num;
        num = k * (int'(t) - 8);
        if (num < 0) begin
            f_offset = OFF_W'(-((-num + 8) >>> 4));
        end else begin
            f_offset = OFF_W'((num + 8) >>> 4);
        end
    endfunction

    // lower-indexed candidate a wins ties
    function automatic t_cand f_pick(input t_cand a, input t_cand b);
        if (b.vld && (!a.vld || (b.dval < a.dval))) begin
            f_pick = b;
        end else begin
            f_pick = a;
        end
    endfunction

endpackage

// ===== rtl/odpq_in_if.sv =====
interface odpq_in_if;
    import odpq_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [CHAN_W-1:0]  red_in;
    logic [CHAN_W-1:0]  green_in;
    logic [CHAN_W-1:0]  blue_in;

    modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                    input ready);
    modport sink (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  output ready);
endinterface

// ===== rtl/odpq_out_if.sv =====
interface odpq_out_if;
    import odpq_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] color_index;
    logic             exact_hit;

    modport source (output valid, color_index, exact_hit, input ready);
    modport sink (input valid, color_index, exact_hit, output ready);
endinterface

// ===== rtl/odpq_dist_lane.sv =====
module odpq_dist_lane (
    input  logic                                  i_clk,
    input  odpq_pkg::t_lane_en                    i_en,
    input  logic signed [odpq_pkg::D_W-1:0]       i_dr,
    input  logic signed [odpq_pkg::D_W-1:0]       i_dg,
    input  logic signed [odpq_pkg::D_W-1:0]       i_db,
    output logic [odpq_pkg::DIST_W-1:0]           o_dist
);
    import odpq_pkg::*;

    localparam logic signed [P_W-1:0] WR = P_W'(W_RED);
    localparam logic signed [P_W-1:0] WG = P_W'(W_GREEN);
    localparam logic signed [P_W-1:0] WB = P_W'(W_BLUE);

    logic signed [P_W-1:0]   r_pr, r_pg, r_pb;
    logic signed [P_W-1:0]   n_pr, n_pg, n_pb;
    logic signed [2*P_W-1:0] n_sr, n_sg, n_sb;
    logic [DIST_W-1:0]       r_sr, r_sg, r_sb;
    logic [DIST_W-1:0]       r_dist;

    // weighted differences
    assign n_pr = P_W'(i_dr) * WR;
    assign n_pg = P_W'(i_dg) * WG;
    assign n_pb = P_W'(i_db) * WB;

    // squares, always non-negative and below 2^29
    assign n_sr = r_pr * r_pr;
    assign n_sg = r_pg * r_pg;
    assign n_sb = r_pb * r_pb;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_pr <= n_pr;
            r_pg <= n_pg;
            r_pb <= n_pb;
        end
        if (i_en.s4) begin
            r_sr <= n_sr[DIST_W-1:0];
            r_sg <= n_sg[DIST_W-1:0];
            r_sb <= n_sb[DIST_W-1:0];
        end
        if (i_en.s5) begin
            r_dist <= r_sr + r_sg + r_sb;
        end
    end

    assign o_dist = r_dist;

endmodule

// ===== rtl/ordered_dither_palette_quantizer_core.sv =====
// ordered-dither palette quantizer: takes one rgb888 pixel word with its x,y
// position per clock and returns one palette index word per pixel, in order.
// a pixel equal to an in-use palette entry returns the lowest such index with
// exact_hit set; otherwise a 4x4 bayer threshold adds per-channel offsets
// (no clamping) and the entry with the smallest (30dr)^2+(59dg)^2+(11db)^2
// wins, lowest index on ties. throughput is one word per clock while the
// output is not held; the pipeline registers offset add, palette compare and
// differences, weighting, squaring, summing and three levels of the min tree,
// each in its own stage. every stage holds its own valid bit and only moves
// when the stage after it is empty or moving, so output back-pressure fills
// bubbles first and then stalls the input. configuration (color count and
// seven palette entries) is written through the plain write port and must
// only change while the pipeline is empty. color_count of zero yields index
// 0 with exact_hit clear.
module ordered_dither_palette_quantizer_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [odpq_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [odpq_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    odpq_in_if.sink                              i_pix,
    odpq_out_if.source                           o_res
);
    import odpq_pkg::*;

    localparam int NSTG = 8;

    // configuration registers
    logic [CNT_W-1:0] r_count;
    logic [RGB_W-1:0] r_pal [NUM_PAL];
    logic [CNT_W-1:0] n_use;

    // pipeline control
    logic [NSTG:1] r_vld;
    logic [NSTG:1] n_en;

    // stage 1: dithered channels and raw pixel
    logic signed [D_W-1:0]   r_s1_r1, r_s1_g1, r_s1_b1;
    logic [RGB_W-1:0]        r_s1_rgb;
    logic [3:0]              n_thr;
    logic signed [OFF_W-1:0] n_off_r, n_off_g, n_off_b;

    // stage 2: per-entry differences, exact match
    logic signed [D_W-1:0] r_s2_dr [NUM_PAL];
    logic signed [D_W-1:0] r_s2_dg [NUM_PAL];
    logic signed [D_W-1:0] r_s2_db [NUM_PAL];
    t_side                 n_side2;

    // sideband for stages 2..7
    t_side r_side [2:7];

    // lanes and min tree
    t_lane_en          n_lane_en;
    logic [DIST_W-1:0] w_dist [NUM_PAL];
    t_cand             n_c5 [NUM_PAL];
    t_cand             r_c6 [L6_N];
    t_cand             r_c7 [L7_N];
    t_cand             n_best;

    // output register
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_hit;

    // ---------------------------------------------------------------
    // configuration
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
            for (int i = 0; i < NUM_PAL; i++) begin
                r_pal[i] <= PAL_RESET[i];
            end
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_COUNT: begin
                    r_count <= i_cfg_data[CNT_W-1:0];
                end
                default: begin
                    r_pal[i_cfg_idx - REG_PAL0] <= i_cfg_data;
                end
            endcase
        end
    end

    // entries in use, capped at capacity
    assign n_use = (r_count > CNT_W'(N_USE_MAX)) ? CNT_W'(N_USE_MAX) : r_count;

    // ---------------------------------------------------------------
    // stage enables: a stage loads when empty or when its successor moves
    // ---------------------------------------------------------------
    always_comb begin
        n_en[NSTG] = !r_vld[NSTG] || o_res.ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            n_en[k] = !r_vld[k] || n_en[k+1];
        end
    end

    assign i_pix.ready = n_en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (n_en[1]) begin
                r_vld[1] <= i_pix.valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (n_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: bayer threshold lookup and offset add
    // ---------------------------------------------------------------
    assign n_thr   = BAYER[i_pix.pixel_x[1:0]][i_pix.pixel_y[1:0]];
    assign n_off_r = f_offset(K_RED, n_thr);
    assign n_off_g = f_offset(K_GREEN, n_thr);
    assign n_off_b = f_offset(K_BLUE, n_thr);

    always_ff @(posedge i_clk) begin
        if (n_en[1]) begin
            r_s1_r1  <= $signed({2'b00, i_pix.red_in}) + D_W'(n_off_r);
            r_s1_g1  <= $signed({2'b00, i_pix.green_in}) + D_W'(n_off_g);
            r_s1_b1  <= $signed({2'b00, i_pix.blue_in}) + D_W'(n_off_b);
            r_s1_rgb <= {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        end
    end

    // ---------------------------------------------------------------
    // stage 2: exact match (lowest index) and channel differences
    // ---------------------------------------------------------------
    always_comb begin
        n_side2.hit  = 1'b0;
        n_side2.hidx = '0;
        for (int i = 0; i < NUM_PAL; i++) begin
            n_side2.mask[i] = CNT_W'(i) < n_use;
        end
        for (int i = NUM_PAL - 1; i >= 0; i--) begin
            if (n_side2.mask[i] && (r_pal[i] == r_s1_rgb)) begin
                n_side2.hit  = 1'b1;
                n_side2.hidx = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            for (int i = 0; i < NUM_PAL; i++) begin
                r_s2_dr[i] <= $signed({2'b00, r_pal[i][23:16]}) - r_s1_r1;
                r_s2_dg[i] <= $signed({2'b00, r_pal[i][15:8]}) - r_s1_g1;
                r_s2_db[i] <= $signed({2'b00, r_pal[i][7:0]}) - r_s1_b1;
            end
        end
    end

    // sideband follows the data through the distance stages
    always_ff @(posedge i_clk) begin
        if (n_en[2]) begin
            r_side[2] <= n_side2;
        end
        for (int k = 3; k <= 7; k++) begin
            if (n_en[k]) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ---------------------------------------------------------------
    // stages 3..5: weighted squared distance per palette entry
    // ---------------------------------------------------------------
    assign n_lane_en = '{s3: n_en[3], s4: n_en[4], s5: n_en[5]};

    for (genvar g = 0; g < NUM_PAL; g++) begin : g_lane
        odpq_dist_lane u_lane (
            .i_clk  (i_clk),
            .i_en   (n_lane_en),
            .i_dr   (r_s2_dr[g]),
            .i_dg   (r_s2_dg[g]),
            .i_db   (r_s2_db[g]),
            .o_dist (w_dist[g])
        );
    end

    // ---------------------------------------------------------------
    // stages 6..8: min tree, left (lower index) wins ties
    // ---------------------------------------------------------------
    always_comb begin
        for (int i = 0; i < NUM_PAL; i++) begin
            n_c5[i].vld  = r_side[5].mask[i];
            n_c5[i].idx  = IDX_W'(i);
            n_c5[i].dval = w_dist[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en[6]) begin
            for (int j = 0; j < L6_N; j++) begin
                if (2 * j + 1 < NUM_PAL) begin
                    r_c6[j] <= f_pick(n_c5[2*j], n_c5[2*j+1]);
                end else begin
                    r_c6[j] <= n_c5[2*j];
                end
            end
        end
        if (n_en[7]) begin
            for (int j = 0; j < L7_N; j++) begin
                if (2 * j + 1 < L6_N) begin
                    r_c7[j] <= f_pick(r_c6[2*j], r_c6[2*j+1]);
                end else begin
                    r_c7[j] <= r_c6[2*j];
                end
            end
        end
    end

    // final pair; no valid candidate leaves index 0
    assign n_best = f_pick(r_c7[0], r_c7[L7_N-1]);

    always_ff @(posedge i_clk) begin
        if (n_en[8]) begin
            r_out_hit <= r_side[7].hit;
            if (r_side[7].hit) begin
                r_out_idx <= r_side[7].hidx;
            end else if (n_best.vld) begin
                r_out_idx <= n_best.idx;
            end else begin
                r_out_idx <= '0;
            end
        end
    end

    assign o_res.valid       = r_vld[NSTG];
    assign o_res.color_index = r_out_idx;
    assign o_res.exact_hit   = r_out_hit;

`ifndef SYNTHESIS
    // input only stalls when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (&r_vld) && !o_res.ready)
        else $error("input stalled with a bubble in the pipeline");

    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_vld == '0))
        else $error("valid bits survived reset");

    // an exact hit points at an entry in use
    a_hit_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.exact_hit |-> (CNT_W'(o_res.color_index) < n_use))
        else $error("exact hit on an entry not in use");

    // nearest entry is in use whenever any is
    a_near_in_use: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (n_use != '0) |-> (CNT_W'(o_res.color_index) < n_use))
        else $error("nearest entry not in use");

    // no entries in use gives index zero without a hit
    a_empty_palette: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && (n_use == '0) |-> (o_res.color_index == '0) && !o_res.exact_hit)
        else $error("result with empty palette");
`endif

endmodule
